FILE: rtl/lrsd_pkg.sv
// lrsd_pkg: result codes, mode codes, the result entry type and keyword
// letters for the line/raw stream deframer.
// No dependencies.
package lrsd_pkg;

	localparam logic [2:0] KIND_LINE_BYTE = 3'd0;
	localparam logic [2:0] KIND_LINE_END  = 3'd1;
	localparam logic [2:0] KIND_RAW_BYTE  = 3'd2;
	localparam logic [2:0] KIND_RAW_END   = 3'd3;
	localparam logic [2:0] KIND_ERROR     = 3'd4;

	localparam logic [1:0] MODE_LINE  = 2'd0;
	localparam logic [1:0] MODE_COUNT = 2'd1;
	localparam logic [1:0] MODE_DATA  = 2'd2;
	localparam logic [1:0] MODE_HALT  = 2'd3;

	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;

	localparam logic [2:0] START_LEN = 3'd3;
	localparam logic [2:0] STOP_LEN  = 3'd6;

	localparam int RES_DEPTH = 4;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
	} res_t;

	// Letters of "RAW".
	function automatic logic [7:0] start_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = 8'h52;
			2'd1:    c = 8'h41;
			2'd2:    c = 8'h57;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Letters of "ENDRAW".
	function automatic logic [7:0] stop_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h45;
			3'd1:    c = 8'h4E;
			3'd2:    c = 8'h44;
			3'd3:    c = 8'h52;
			3'd4:    c = 8'h41;
			3'd5:    c = 8'h57;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/line_raw_stream_deframer.sv
// line_raw_stream_deframer: splits a byte stream into line bytes and raw
// data blocks, with a four-entry result buffer on the output side.
// Depends on lrsd_pkg.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid, in_stall, in_byte      | request in
//  out     | out_valid, out_stall, out_kind,  | request out
//          | out_byte, last                   |
//
// A byte is registered on acceptance and decoded in the next cycle into
// zero to four results, which load the result buffer and leave one per cycle
// while out_stall is low, so one byte per cycle if each byte yields at most
// one result; after a "RAW" flush the next byte waits until all have left.
// Reset clears mode and parser state; a stalled output holds the buffer and
// lets one more byte wait in the input register before in_stall rises.
module line_raw_stream_deframer
	import lrsd_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] out_kind,
	output logic [7:0] out_byte,
	output logic       last
);

	localparam int PW = COUNT_WIDTH + 4;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// parser state
	logic [1:0]             mode_q;
	logic [2:0]             depth_q;
	logic                   started_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   has_digit_q;
	logic [COUNT_WIDTH-1:0] left_q;

	// result buffer, entry 0 is presented
	res_t       res_q [RES_DEPTH];
	logic [2:0] rem_q;

	logic pop;
	logic buf_free;
	logic go;

	// next-state and result logic
	logic [1:0]             mode_d;
	logic [2:0]             depth_d;
	logic                   started_d;
	logic [COUNT_WIDTH-1:0] count_d;
	logic                   has_digit_d;
	logic [COUNT_WIDTH-1:0] left_d;
	logic [1:0]             flush_cnt;
	logic                   fin_en;
	res_t                   fin;
	logic [2:0]             n_res;
	res_t                   new_res [RES_DEPTH];
	logic                   is_digit;
	logic [PW-1:0]          prod;
	logic                   ovf;

	assign pop      = out_valid && !out_stall;
	assign buf_free = (rem_q == 3'd0) || (rem_q == 3'd1 && pop);
	assign go       = valid_s1 && buf_free;
	assign in_stall = valid_s1 && !buf_free;

	assign out_valid = (rem_q != 3'd0);
	assign out_kind  = res_q[0].kind;
	assign out_byte  = res_q[0].data;
	assign last      = (rem_q == 3'd1);

	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign prod = ({4'd0, count_q} << 3) + ({4'd0, count_q} << 1)
		+ {{(PW-4){1'b0}}, byte_s1[3:0]};
	assign ovf = |prod[PW-1:COUNT_WIDTH];

	always_comb begin
		mode_d      = mode_q;
		depth_d     = depth_q;
		started_d   = started_q;
		count_d     = count_q;
		has_digit_d = has_digit_q;
		left_d      = left_q;
		flush_cnt   = 2'd0;
		fin_en      = 1'b0;
		fin.kind    = KIND_ERROR;
		fin.data    = 8'h00;
		case (mode_q)
			MODE_LINE: begin
				if (byte_s1 == CHAR_NEWLINE) begin
					if (!started_q && depth_q == START_LEN) begin
						mode_d = MODE_COUNT;
					end else begin
						flush_cnt = depth_q[1:0];
						fin_en    = 1'b1;
						fin.kind  = KIND_LINE_END;
					end
					depth_d     = 3'd0;
					started_d   = 1'b0;
					count_d     = '0;
					has_digit_d = 1'b0;
				end else if (started_q) begin
					fin_en   = 1'b1;
					fin.kind = KIND_LINE_BYTE;
					fin.data = byte_s1;
				end else if (depth_q < START_LEN && byte_s1 == start_char(depth_q[1:0])) begin
					depth_d = depth_q + 3'd1;
				end else begin
					// mismatch: release the held letters ahead of this byte
					flush_cnt = depth_q[1:0];
					fin_en    = 1'b1;
					fin.kind  = KIND_LINE_BYTE;
					fin.data  = byte_s1;
					depth_d   = 3'd0;
					started_d = 1'b1;
				end
			end
			MODE_COUNT: begin
				if (byte_s1 == CHAR_NEWLINE) begin
					if (depth_q == STOP_LEN) begin
						fin_en   = 1'b1;
						fin.kind = KIND_RAW_END;
						mode_d   = MODE_LINE;
					end else if (depth_q == 3'd0 && has_digit_q) begin
						if (count_q != '0) begin
							left_d = count_q;
							mode_d = MODE_DATA;
						end
					end else begin
						fin_en = 1'b1;
						mode_d = MODE_HALT;
					end
					depth_d     = 3'd0;
					started_d   = 1'b0;
					count_d     = '0;
					has_digit_d = 1'b0;
				end else if (is_digit) begin
					if (depth_q != 3'd0 || ovf) begin
						fin_en      = 1'b1;
						mode_d      = MODE_HALT;
						depth_d     = 3'd0;
						started_d   = 1'b0;
						count_d     = '0;
						has_digit_d = 1'b0;
					end else begin
						count_d     = prod[COUNT_WIDTH-1:0];
						has_digit_d = 1'b1;
					end
				end else if (!has_digit_q && depth_q < STOP_LEN
						&& byte_s1 == stop_char(depth_q)) begin
					depth_d = depth_q + 3'd1;
				end else begin
					fin_en      = 1'b1;
					mode_d      = MODE_HALT;
					depth_d     = 3'd0;
					started_d   = 1'b0;
					count_d     = '0;
					has_digit_d = 1'b0;
				end
			end
			MODE_DATA: begin
				fin_en   = 1'b1;
				fin.kind = KIND_RAW_BYTE;
				fin.data = byte_s1;
				if (left_q != '0) begin
					left_d = left_q - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
				end
				if (left_q == '0 || left_q == {{(COUNT_WIDTH-1){1'b0}}, 1'b1}) begin
					mode_d = MODE_COUNT;
				end
			end
			default: begin
				// halted: drop every byte
			end
		endcase
	end

	assign n_res = {1'b0, flush_cnt} + {2'b00, fin_en};

	always_comb begin
		for (int i = 0; i < RES_DEPTH; i++) begin
			if (i < int'(flush_cnt)) begin
				new_res[i].kind = KIND_LINE_BYTE;
				new_res[i].data = start_char(2'(i));
			end else begin
				new_res[i] = fin;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_LINE;
			depth_q     <= 3'd0;
			started_q   <= 1'b0;
			count_q     <= '0;
			has_digit_q <= 1'b0;
			left_q      <= '0;
		end else if (go) begin
			mode_q      <= mode_d;
			depth_q     <= depth_d;
			started_q   <= started_d;
			count_q     <= count_d;
			has_digit_q <= has_digit_d;
			left_q      <= left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (go) begin
			rem_q <= n_res;
		end else if (pop) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	// load a fresh set of results, or advance the queue on a pop
	always_ff @(posedge clk) begin
		if (go) begin
			for (int i = 0; i < RES_DEPTH; i++) begin
				res_q[i] <= new_res[i];
			end
		end else if (pop) begin
			for (int i = 0; i < RES_DEPTH - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
	end

endmodule

FILE: verif/line_raw_stream_deframer_test.sv
// Testbench for line_raw_stream_deframer: directed and shaped random byte streams,
// with each result checked against a predictor written in this file.
// Depends on lrsd_pkg and the line_raw_stream_deframer RTL.
module line_raw_stream_deframer_test;
	import lrsd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 20;

	localparam longint unsigned COUNT_MAX = 64'h0000_0000_FFFF_FFFF;
	localparam logic [23:0] OPEN_WORD  = "RAW";
	localparam logic [47:0] CLOSE_WORD = "ENDRAW";

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic       last;
	} deframe_res_t;

	typedef enum int {
		HALT_EMPTY_LINE,
		HALT_BAD_CHAR,
		HALT_DIGIT_IN_WORD,
		HALT_NEWLINE_IN_WORD,
		HALT_OVERFLOW
	} halt_cause_e;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] out_kind;
	logic [7:0] out_byte;
	logic       last;

	// predictor state
	logic [1:0]      pm_mode      = MODE_LINE;
	logic [2:0]      pm_depth     = 3'd0;
	logic            pm_started   = 1'b0;
	longint unsigned pm_count     = 0;
	logic            pm_has_digit = 1'b0;
	longint unsigned pm_left      = 0;

	deframe_res_t byte_results[$];
	deframe_res_t pending_results[$];

	int err_count     = 0;
	int send_idle_pct = 22;
	int recv_idle_pct = 62;
	int hold_req      = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;

	line_raw_stream_deframer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_kind  (out_kind),
		.out_byte  (out_byte),
		.last      (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [7:0] open_char(input int idx);
		return OPEN_WORD[8*(2-idx) +: 8];
	endfunction

	function automatic logic [7:0] close_char(input int idx);
		return CLOSE_WORD[8*(5-idx) +: 8];
	endfunction

	task automatic push_result(input logic [2:0] kind, input logic [7:0] data);
		deframe_res_t r;
		r.kind = kind;
		r.data = data;
		r.last = 1'b0;
		byte_results.push_back(r);
	endtask

	task automatic clear_line();
		pm_depth     = 3'd0;
		pm_started   = 1'b0;
		pm_count     = 0;
		pm_has_digit = 1'b0;
	endtask

	task automatic flush_held();
		for (int i = 0; i < pm_depth && i < START_LEN; i++)
			push_result(KIND_LINE_BYTE, open_char(i));
		pm_depth = 3'd0;
	endtask

	task automatic take_error();
		push_result(KIND_ERROR, 8'h00);
		pm_mode = MODE_HALT;
		clear_line();
	endtask

	// Advance the predicted state by one accepted byte and queue its results.
	task automatic predict_byte(input logic [7:0] b);
		longint unsigned d;
		deframe_res_t r;
		byte_results.delete();
		case (pm_mode)
			MODE_LINE: begin
				if (b == CHAR_NEWLINE) begin
					if (!pm_started && pm_depth == START_LEN) begin
						clear_line();
						pm_mode = MODE_COUNT;
					end else begin
						flush_held();
						push_result(KIND_LINE_END, 8'h00);
						clear_line();
					end
				end else if (pm_started) begin
					push_result(KIND_LINE_BYTE, b);
				end else if (pm_depth < START_LEN && b == open_char(int'(pm_depth))) begin
					pm_depth = pm_depth + 3'd1;
				end else begin
					flush_held();
					push_result(KIND_LINE_BYTE, b);
					pm_started = 1'b1;
				end
			end
			MODE_COUNT: begin
				if (b == CHAR_NEWLINE) begin
					if (pm_depth == STOP_LEN) begin
						push_result(KIND_RAW_END, 8'h00);
						clear_line();
						pm_mode = MODE_LINE;
					end else if (pm_depth == 0 && pm_has_digit) begin
						// a zero count keeps waiting for another count line
						if (pm_count != 0) begin
							pm_left = pm_count;
							pm_mode = MODE_DATA;
						end
						clear_line();
					end else begin
						take_error();
					end
				end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
					d = 64'(b - CHAR_ZERO);
					if (pm_depth != 0 || pm_count > (COUNT_MAX - d) / 10) begin
						take_error();
					end else begin
						pm_count     = pm_count * 10 + d;
						pm_has_digit = 1'b1;
					end
				end else if (!pm_has_digit && pm_depth < STOP_LEN
						&& b == close_char(int'(pm_depth))) begin
					pm_depth = pm_depth + 3'd1;
				end else begin
					take_error();
				end
			end
			MODE_DATA: begin
				push_result(KIND_RAW_BYTE, b);
				if (pm_left > 0)
					pm_left = pm_left - 1;
				if (pm_left == 0)
					pm_mode = MODE_COUNT;
			end
			default: ;
		endcase
		if (byte_results.size() != 0) begin
			r = byte_results.pop_back();
			r.last = 1'b1;
			byte_results.push_back(r);
		end
		while (byte_results.size() != 0)
			pending_results.push_back(byte_results.pop_front());
	endtask

	// Offer one request and hold it until accepted; valid stays high afterwards.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_byte(b);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Pick the next byte from the predicted state so that most streams stay well formed.
	task automatic send_shaped_byte();
		logic [7:0] b;
		logic [7:0] digit;
		b     = 8'($urandom_range(255));
		digit = CHAR_ZERO + 8'($urandom_range(9));
		case (pm_mode)
			MODE_LINE: begin
				if (!pm_started && pm_depth < START_LEN
						&& $urandom_range(99) < (pm_depth == 0 ? 60 : 80))
					b = open_char(int'(pm_depth));
				else if (!pm_started && pm_depth == START_LEN && $urandom_range(99) < 70)
					b = CHAR_NEWLINE;
				else if ($urandom_range(99) < 15)
					b = CHAR_NEWLINE;
			end
			MODE_COUNT: begin
				if (pm_depth != 0)
					b = (pm_depth == STOP_LEN) ? CHAR_NEWLINE : close_char(int'(pm_depth));
				else if (!pm_has_digit)
					b = ($urandom_range(99) < 30) ? close_char(0) : digit;
				else if (pm_count < 3 && $urandom_range(99) < 40)
					b = digit;
				else
					b = CHAR_NEWLINE;
			end
			default: ;
		endcase
		send_byte(b);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic test_line_bytes();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CHAR_NEWLINE);
		send_byte(CHAR_NEWLINE);
	endtask

	task automatic test_start_word_prefix();
		send_text("RAWW\n");
		send_text("RA\n");
	endtask

	task automatic test_raw_block();
		send_text("RAW\n");
		send_text("0\n");
		send_text("1\n");
		send_byte(CHAR_NEWLINE);
		send_text("ENDRAW\n");
		wait_drained();
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
		repeat (n)
			send_shaped_byte();
		wait_drained();
	endtask

	// Hold the output off for a long stretch while requests keep coming.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		hold_req <= hold_req + 1;
		repeat (40)
			send_shaped_byte();
		wait_drained();
	endtask

	task automatic test_halt_on_error();
		halt_cause_e cause;
		logic [7:0] b;
		int n_letters;
		send_idle_pct = 22;
		recv_idle_pct <= 22;
		// walk to the start of a fresh count line
		while (!(pm_mode == MODE_COUNT && pm_depth == 0 && !pm_has_digit)) begin
			case (pm_mode)
				MODE_LINE: begin
					if (!pm_started && pm_depth < START_LEN)
						send_byte(open_char(int'(pm_depth)));
					else
						send_byte(CHAR_NEWLINE);
				end
				MODE_COUNT: begin
					if (pm_depth != 0 && pm_depth != STOP_LEN)
						send_byte(close_char(int'(pm_depth)));
					else
						send_byte(CHAR_NEWLINE);
				end
				default: send_byte(8'($urandom_range(255)));
			endcase
		end
		cause = halt_cause_e'($urandom_range(4));
		case (cause)
			HALT_EMPTY_LINE: send_byte(CHAR_NEWLINE);
			HALT_BAD_CHAR: begin
				do
					b = 8'($urandom_range(255));
				while ((b >= CHAR_ZERO && b <= CHAR_NINE) || b == close_char(0)
						|| b == CHAR_NEWLINE);
				send_byte(b);
			end
			HALT_DIGIT_IN_WORD, HALT_NEWLINE_IN_WORD: begin
				n_letters = $urandom_range(1, 5);
				for (int i = 0; i < n_letters; i++)
					send_byte(close_char(i));
				if (cause == HALT_DIGIT_IN_WORD)
					send_byte(CHAR_ZERO + 8'($urandom_range(9)));
				else
					send_byte(CHAR_NEWLINE);
			end
			default: begin
				// largest count first, then one more digit overflows
				send_text("4294967295");
				send_byte(CHAR_ZERO + 8'($urandom_range(9)));
			end
		endcase
		// halted: drop everything from here on
		send_text("RAW\n1\n");
		repeat (8)
			send_byte(8'($urandom_range(255)));
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			out_stall <= 1'b1;
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		deframe_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: kind %0d byte %0h last %0b",
					$time, out_kind, out_byte, last);
				err_count++;
			end else begin
				e = pending_results.pop_front();
				if (out_kind !== e.kind) begin
					$display("%0t out_kind: expected %0d, got %0d", $time, e.kind, out_kind);
					err_count++;
				end
				if (out_byte !== e.data) begin
					$display("%0t out_byte: expected %0h, got %0h", $time, e.data, out_byte);
					err_count++;
				end
				if (last !== e.last) begin
					$display("%0t last: expected %0b, got %0b", $time, e.last, last);
					err_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no request moved for %0d cycles", $time, quiet_cycles);
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_line_bytes();
		test_start_word_prefix();
		test_raw_block();
		test_random_traffic(22, 62, 90);
		test_random_traffic(62, 22, 90);
		test_random_traffic(0, 0, 80);
		test_output_backpressure();
		test_halt_on_error();
		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
